FILE: rtl/lol_pkg.sv
// Package for the layer order list: payload types, mode and status codes,
// cell control structs and parameter defaults. No dependencies.
`default_nettype none

package lol_pkg;

	// Defaults for the top-level parameters.
	localparam int DEPTH_DEF   = 16;
	localparam int ID_BITS_DEF = 8;

	// Command modes.
	localparam logic [2:0] MODE_APPEND   = 3'd0;
	localparam logic [2:0] MODE_FRONT    = 3'd1;
	localparam logic [2:0] MODE_BACK     = 3'd2;
	localparam logic [2:0] MODE_FORWARD  = 3'd3;
	localparam logic [2:0] MODE_BACKWARD = 3'd4;

	// Response status codes.
	localparam logic [1:0] STATUS_DONE   = 2'd0;
	localparam logic [1:0] STATUS_ABSENT = 2'd1;
	localparam logic [1:0] STATUS_FULL   = 2'd2;

	// Payload of one command transaction.
	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] item_id;
	} cmd_item_t;

	// Payload of one response transaction.
	typedef struct packed {
		logic [1:0] status;
		logic [3:0] new_position;
		logic [4:0] count;
	} rsp_item_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic       capture;
		logic       apply;
		logic       found;
		logic [2:0] mode;
	} cell_cmd_t;

	// Where a cell stands relative to the live part of the list.
	typedef struct packed {
		logic live;
		logic last;
		logic tail;
	} cell_pos_t;

endpackage

`default_nettype wire

FILE: rtl/lol_stream_if.sv
// Valid/ready stream interface used by the command and response channels.
// The payload type is a parameter; no other dependencies.
`default_nettype none

interface lol_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/layer_order_list.sv
// Layer order list top level: command/response handshake, entry count and
// the chain of list cells. Depends on lol_pkg, lol_stream_if and lol_cell.
//
// Each command is accepted in ST_IDLE, where every cell compares its slot
// with the identifier and registers a match flag. In ST_APPLY, once the
// output register is free, the first match is found along the cell chain,
// every cell loads its new value from itself or a neighbor, and the response
// is loaded into the output register. No new command is accepted until the
// block is back in ST_IDLE; a response that is not taken stalls only the
// update of the following command. Position 0 is the front of the list.
// Moves act on the matching entry nearest the front.
`default_nettype none

module layer_order_list #(
	parameter int DEPTH   = lol_pkg::DEPTH_DEF,
	parameter int ID_BITS = lol_pkg::ID_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lol_stream_if.sink   cmd,
	lol_stream_if.source rsp
);
	import lol_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_APPLY = 2'b10
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [2:0]         mode_q;
	logic [ID_BITS-1:0] id_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic               accept;
	logic               go;
	logic [ID_BITS+7:0] id_ext;
	logic [ID_BITS-1:0] id_in;
	logic [ID_BITS-1:0] cur_id;
	cell_cmd_t          cell_ctrl;

	logic [ID_BITS-1:0] slot_w [DEPTH];
	logic [DEPTH:0]     before_w;
	logic [DEPTH-1:0]   first_w;

	logic [CNT_W-1:0]   at_idx;
	logic [CNT_W-1:0]   last_idx;
	logic [CNT_W-1:0]   pos_new;
	logic [CNT_W-1:0]   count_new;
	logic [1:0]         status_new;
	logic [CNT_W+3:0]   pos_ext;
	logic [CNT_W+4:0]   cnt_ext;

	// Handshake and command capture.
	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && (state_q == ST_IDLE);
	assign go        = (state_q == ST_APPLY) && (!rsp_valid_q || rsp.ready);

	assign id_ext = {{ID_BITS{1'b0}}, cmd.data.item_id};
	assign id_in  = id_ext[ID_BITS-1:0];
	assign cur_id = (state_q == ST_APPLY) ? id_q : id_in;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= cmd.data.mode;
			id_q   <= id_in;
		end
	end

	// Sequencer: accept, then update once the output register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Chain of cells.
	assign cell_ctrl.capture = accept;
	assign cell_ctrl.apply   = go;
	assign cell_ctrl.found   = before_w[DEPTH];
	assign cell_ctrl.mode    = mode_q;
	assign before_w[0]       = 1'b0;
	assign last_idx          = count_q - 1'b1;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [ID_BITS-1:0] prev_slot;
		logic [ID_BITS-1:0] next_slot;
		logic               prev_first;
		logic               next_first;
		cell_pos_t          pos;

		// The front cell sees the command identifier as its predecessor.
		if (k == 0) begin : g_front
			assign prev_slot  = cur_id;
			assign prev_first = 1'b0;
		end else begin : g_inner_prev
			assign prev_slot  = slot_w[k-1];
			assign prev_first = first_w[k-1];
		end

		if (k == DEPTH - 1) begin : g_back
			assign next_slot  = cur_id;
			assign next_first = 1'b0;
		end else begin : g_inner_next
			assign next_slot  = slot_w[k+1];
			assign next_first = first_w[k+1];
		end

		assign pos.live = CNT_W'(k) < count_q;
		assign pos.last = CNT_W'(k) == last_idx;
		assign pos.tail = CNT_W'(k) == count_q;

		lol_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.pos       (pos),
			.id        (cur_id),
			.prev_slot (prev_slot),
			.next_slot (next_slot),
			.before_in (before_w[k]),
			.prev_first(prev_first),
			.next_first(next_first),
			.slot      (slot_w[k]),
			.before_out(before_w[k+1]),
			.first     (first_w[k])
		);
	end

	// Binary index of the first matching cell.
	always_comb begin
		at_idx = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (first_w[k]) begin
				at_idx = at_idx | CNT_W'(k);
			end
		end
	end

	// Response fields and the new entry count.
	always_comb begin
		status_new = STATUS_DONE;
		pos_new    = '0;
		count_new  = count_q;
		case (mode_q)
			MODE_APPEND: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					status_new = STATUS_FULL;
				end else begin
					pos_new   = count_q;
					count_new = count_q + 1'b1;
				end
			end
			MODE_FRONT, MODE_BACK, MODE_FORWARD, MODE_BACKWARD: begin
				if (!before_w[DEPTH]) begin
					status_new = STATUS_ABSENT;
				end else if (mode_q == MODE_FRONT) begin
					pos_new = '0;
				end else if (mode_q == MODE_BACK) begin
					pos_new = last_idx;
				end else if (mode_q == MODE_FORWARD) begin
					pos_new = (at_idx == '0) ? '0 : at_idx - 1'b1;
				end else begin
					pos_new = (at_idx == last_idx) ? last_idx : at_idx + 1'b1;
				end
			end
			default: begin
				status_new = STATUS_DONE;
			end
		endcase
	end

	assign pos_ext = {4'b0, pos_new};
	assign cnt_ext = {5'b0, count_new};

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (go) begin
			count_q <= count_new;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q.status       <= status_new;
			rsp_q.new_position <= pos_ext[3:0];
			rsp_q.count        <= cnt_ext[4:0];
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// The entry count never exceeds the list depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// At most one cell claims to be the first match.
	a_first_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_w))
		else $error("more than one first match");

	// An accepted transaction moves the sequencer to the update state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_APPLY) && !cmd.ready)
		else $error("accept did not start an update");

	// A completed update presents a response and frees the command side.
	a_update_done: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> rsp_valid_q && (state_q == ST_IDLE))
		else $error("update did not present a response");

endmodule

`default_nettype wire

FILE: rtl/lol_cell.sv
// One slot of the layer order list: holds an identifier, flags a match and
// takes its new value from itself, a neighbor or the command identifier.
// Depends on lol_pkg.
`default_nettype none

module lol_cell #(
	parameter int ID_BITS = lol_pkg::ID_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lol_pkg::cell_cmd_t ctrl,
	input  wire lol_pkg::cell_pos_t pos,
	input  wire logic [ID_BITS-1:0] id,
	input  wire logic [ID_BITS-1:0] prev_slot,
	input  wire logic [ID_BITS-1:0] next_slot,
	input  wire logic               before_in,
	input  wire logic               prev_first,
	input  wire logic               next_first,
	output logic [ID_BITS-1:0]      slot,
	output logic                    before_out,
	output logic                    first
);
	import lol_pkg::*;

	logic [ID_BITS-1:0] slot_q;
	logic               match_q;
	logic               wr_en;
	logic [ID_BITS-1:0] wr_data;

	// Match flag is taken when a transaction is accepted and held until the update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.capture) begin
			match_q <= pos.live && (slot_q == id);
		end
	end

	// A match further toward the front ripples down the chain.
	assign before_out = before_in | match_q;
	assign first      = match_q & ~before_in;

	// Select the new slot value for the commanded move.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = id;
		case (ctrl.mode)
			MODE_APPEND: begin
				wr_en = pos.tail;
			end
			MODE_FRONT: begin
				wr_en   = ctrl.found && !before_in;
				wr_data = prev_slot;
			end
			MODE_BACK: begin
				wr_en   = pos.live && (before_in || first);
				wr_data = pos.last ? id : next_slot;
			end
			MODE_FORWARD: begin
				if (next_first) begin
					wr_en = 1'b1;
				end else if (first) begin
					wr_en   = 1'b1;
					wr_data = prev_slot;
				end
			end
			MODE_BACKWARD: begin
				if (prev_first && pos.live) begin
					wr_en = 1'b1;
				end else if (first) begin
					wr_en   = 1'b1;
					wr_data = pos.last ? id : next_slot;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Slot storage; contents are undefined until written.
	always_ff @(posedge clk) begin
		if (ctrl.apply && wr_en) begin
			slot_q <= wr_data;
		end
	end

	assign slot = slot_q;

endmodule

`default_nettype wire

FILE: tb/layer_order_checker.sv
// Checker for the layer order list: watches the command and response channels,
// keeps its own copy of the list and compares every response with its prediction.
// Depends on lol_pkg for the payload types and the mode and status codes.
`timescale 1ns / 100ps

module layer_order_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	input  wire logic               cmd_ready,
	input  wire lol_pkg::cmd_item_t cmd_data,
	input  wire logic               rsp_valid,
	input  wire logic               rsp_ready,
	input  wire lol_pkg::rsp_item_t rsp_data,
	output int                      fail_count,
	output int                      pending
);
	import lol_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// Predicted list contents, front at index 0, and the number of live entries.
	logic [7:0] layer_slots [DEPTH];
	int         live_count;

	// Responses predicted for accepted commands, oldest first.
	rsp_item_t  expected_rsps [$];

	initial begin
		fail_count = 0;
		pending    = 0;
		live_count = 0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	// Applies one command to the predicted list and returns the response it causes.
	function automatic rsp_item_t apply_layer_cmd(input cmd_item_t c);
		rsp_item_t  r;
		int         at;
		int         dest;
		int         last;
		logic [7:0] moved;
		r.status       = STATUS_DONE;
		r.new_position = '0;
		case (c.mode)
			MODE_APPEND: begin
				if (live_count >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					layer_slots[live_count] = c.item_id;
					r.new_position = 4'(live_count);
					live_count++;
				end
			end
			MODE_FRONT, MODE_BACK, MODE_FORWARD, MODE_BACKWARD: begin
				// Moves act on the matching entry nearest the front.
				at = -1;
				for (int i = 0; i < live_count; i++) begin
					if (at < 0 && layer_slots[i] == c.item_id) at = i;
				end
				if (at < 0) begin
					r.status = STATUS_ABSENT;
				end else begin
					last = live_count - 1;
					case (c.mode)
						MODE_FRONT:   dest = 0;
						MODE_BACK:    dest = last;
						MODE_FORWARD: dest = (at > 0) ? at - 1 : 0;
						default:      dest = (at < last) ? at + 1 : last;
					endcase
					// Take the entry out and shift the ones in between toward its old slot.
					moved = layer_slots[at];
					if (at < dest) begin
						for (int k = at; k < dest; k++) layer_slots[k] = layer_slots[k + 1];
					end else begin
						for (int k = at; k > dest; k--) layer_slots[k] = layer_slots[k - 1];
					end
					layer_slots[dest] = moved;
					r.new_position = 4'(dest);
				end
			end
			default: ;
		endcase
		r.count = 5'(live_count);
		return r;
	endfunction

	// Responses are checked before the command of the same edge is predicted;
	// a response can never belong to a command accepted at the same edge.
	always @(posedge clk) begin
		rsp_item_t want;
		if (!arst_n) begin
			live_count = 0;
			expected_rsps.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("response transaction with no command outstanding");
				end else begin
					want = expected_rsps.pop_front();
					check_field("status", int'(rsp_data.status), int'(want.status));
					check_field("new_position", int'(rsp_data.new_position),
						int'(want.new_position));
					check_field("count", int'(rsp_data.count), int'(want.count));
				end
			end
			if (cmd_valid && cmd_ready) begin
				expected_rsps.insert(expected_rsps.size(), apply_layer_cmd(cmd_data));
			end
		end
		pending = expected_rsps.size();
	end

endmodule

FILE: tb/tb_layer_order_list.sv
// Top of the layer order list testbench: clock, reset, command stimulus and
// response back-pressure, and the final verdict.
// Depends on lol_pkg, lol_stream_if, layer_order_list and layer_order_checker.
`timescale 1ns / 100ps

module tb_layer_order_list;
	import lol_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int CHUNKS      = 9;
	localparam int CHUNK_ITEMS = 200;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   fail_count;
	int   pending;
	bit   send_gaps;
	bit   rsp_stalls;

	// Identifiers known to be in the list, used to aim most moves at live entries.
	logic [7:0] listed_ids [$];

	lol_stream_if #(.payload_t(cmd_item_t)) cmd_ch ();
	lol_stream_if #(.payload_t(rsp_item_t)) rsp_ch ();

	layer_order_list #(
		.DEPTH   (DEPTH),
		.ID_BITS (ID_BITS_DEF)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	layer_order_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_ch.valid),
		.cmd_ready  (cmd_ch.ready),
		.cmd_data   (cmd_ch.data),
		.rsp_valid  (rsp_ch.valid),
		.rsp_ready  (rsp_ch.ready),
		.rsp_data   (rsp_ch.data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Response back-pressure in random bursts.
	initial begin
		int stall_len;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_stalls && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_len = $urandom_range(1, 15);
				repeat (stall_len - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Drives one command transaction and returns at the edge that accepts it.
	// Valid stays high afterwards; the next call or the drain task decides.
	task automatic issue_cmd(input logic [2:0] mode, input logic [7:0] id);
		int gap;
		gap = 0;
		if (send_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.data.mode    <= mode;
		cmd_ch.data.item_id <= id;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic append_id(input logic [7:0] id);
		issue_cmd(MODE_APPEND, id);
		if (listed_ids.size() < DEPTH) listed_ids.insert(listed_ids.size(), id);
	endtask

	// Stops sending and waits until every predicted response has arrived.
	task automatic drain_rsps();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Main sequence.
	initial begin
		int         pick;
		logic [2:0] mode;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		arst_n       = 1'b0;
		send_gaps    = 1'b1;
		rsp_stalls   = 1'b1;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Empty list: a move finds nothing, and unused modes change nothing.
		issue_cmd(MODE_FORWARD, 8'h00);
		issue_cmd(3'd5, 8'hFF);
		issue_cmd(3'd6, 8'h80);
		issue_cmd(3'd7, 8'h01);

		// Single entry: it is at the front and the back at once.
		append_id(8'h00);
		issue_cmd(MODE_FRONT, 8'h00);
		issue_cmd(MODE_BACK, 8'h00);
		issue_cmd(MODE_FORWARD, 8'h00);
		issue_cmd(MODE_BACKWARD, 8'h00);

		// Duplicates: moves act on the first match.
		append_id(8'hFF);
		append_id(8'hFF);
		append_id(8'h5A);
		issue_cmd(MODE_BACKWARD, 8'hFF);
		issue_cmd(MODE_BACK, 8'h00);
		issue_cmd(MODE_BACKWARD, 8'h00);
		issue_cmd(MODE_FORWARD, 8'h5A);
		issue_cmd(MODE_FRONT, 8'h5A);
		issue_cmd(MODE_FORWARD, 8'h5A);
		issue_cmd(MODE_BACK, 8'hFF);
		issue_cmd(MODE_BACK, 8'hA5);

		// Fill the list, then append once more to a full list.
		while (listed_ids.size() < DEPTH) append_id(8'($urandom_range(0, 255)));
		issue_cmd(MODE_APPEND, 8'h00);
		issue_cmd(MODE_BACK, listed_ids[0]);
		drain_rsps();

		// Random part: mostly moves of live entries, plus appends, misses and
		// unused modes. The last chunk runs without send gaps or response stalls.
		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			if (chunk == CHUNKS - 1) begin
				send_gaps  = 1'b0;
				rsp_stalls = 1'b0;
			end else begin
				send_gaps  = ($urandom_range(0, 3) != 0);
				rsp_stalls = ($urandom_range(0, 3) != 0);
			end
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					append_id(8'($urandom_range(0, 255)));
				end else if (pick < 14) begin
					issue_cmd(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
				end else begin
					mode = 3'($urandom_range(MODE_FRONT, MODE_BACKWARD));
					if (pick < 22) begin
						issue_cmd(mode, 8'($urandom_range(0, 255)));
					end else begin
						issue_cmd(mode, listed_ids[$urandom_range(0, listed_ids.size() - 1)]);
					end
				end
			end
			// The sender holds off until all responses are in.
			drain_rsps();
		end

		// Let the pipeline settle, then give the verdict.
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
